/* hdl/kvmt_pkg.sv */
// Shared types, codes and sizes for the key/value multimap table.
`default_nettype none

package kvmt_pkg;

    // Default sizes of the table storage.
    localparam int DEF_ENTRIES     = 16;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed widths of the stream fields.
    localparam int MODE_W   = 2;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 3;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 72;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DUMP = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

    // One classified command as it waits in the queue.
    typedef struct packed {
        logic              scan;
        logic [MODE_W-1:0] mode;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] value;
    } t_cmd;

    // Command offer from the front to the back.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

endpackage

`default_nettype wire

/* hdl/kvmt_front.sv */
// Front end: accepts input words, classifies them and queues them for the back end.
`default_nettype none

module kvmt_front
    import kvmt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // tdata fields from bit 0 up: mode[1:0], key[33:2], value[65:34], zero pad.
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,
    output t_cmd_req                 o_req,
    input  wire logic                i_pop
);

    localparam int DEPTH = 2;

    t_cmd             r_slot [DEPTH];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_level;
    t_cmd             w_in;
    logic             w_push;
    logic             w_pop;

    // Decode the incoming word; everything but add walks the table.
    always_comb begin
        w_in.mode  = i_s_axis_tdata[MODE_W-1:0];
        w_in.key   = i_s_axis_tdata[MODE_W +: FIELD_W];
        w_in.value = i_s_axis_tdata[MODE_W+FIELD_W +: FIELD_W];
        w_in.scan  = (i_s_axis_tdata[MODE_W-1:0] != MODE_ADD);
    end

    assign o_s_axis_tready = (r_level != 2'(DEPTH));
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop           = i_pop && (r_level != 2'd0);

    assign o_req.valid = (r_level != 2'd0);
    assign o_req.cmd   = r_slot[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= w_in;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/kvmt_back.sv */
// Back end: holds the table, runs add, delete, find and dump, and drives the result port.
`default_nettype none

module kvmt_back
    import kvmt_pkg::*;
#(
    parameter int ENTRIES     = DEF_ENTRIES,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd_req            i_req,
    output logic                     o_pop,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // tdata fields from bit 0 up: status[2:0], entry_key[34:3], entry_value[66:35], zero pad.
    output logic [M_DATA_W-1:0]      o_m_axis_tdata,
    output logic                     o_m_axis_tlast
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PAD_W = M_DATA_W - STATUS_W - 2 * FIELD_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;

    // Table storage.
    logic [KEY_WIDTH-1:0]   mem_key [ENTRIES];
    logic [VALUE_WIDTH-1:0] mem_val [ENTRIES];

    // Control state.
    logic [2:0]             r_state,  n_state;
    logic [CNT_W-1:0]       r_count,  n_count;
    logic [IDX_W-1:0]       r_idx,    n_idx;
    logic [CNT_W-1:0]       r_w,      n_w;
    logic                   r_pend_valid, n_pend_valid;
    logic                   r_ovalid, n_ovalid;

    // Command and data registers.
    logic [MODE_W-1:0]      r_mode;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [KEY_WIDTH-1:0]   r_rd_key;
    logic [VALUE_WIDTH-1:0] r_rd_val;
    logic [KEY_WIDTH-1:0]   r_pend_key;
    logic [VALUE_WIDTH-1:0] r_pend_val;
    logic [STATUS_W-1:0]    r_ostatus, n_ostatus;
    logic [FIELD_W-1:0]     r_okey,    n_okey;
    logic [FIELD_W-1:0]     r_oval,    n_oval;
    logic                   r_olast,   n_olast;

    // Memory port controls.
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wa;
    logic [KEY_WIDTH-1:0]   mem_wkey;
    logic [VALUE_WIDTH-1:0] mem_wval;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_ra;

    logic                   load_pend;
    logic                   out_free;
    logic                   hit;
    logic                   at_end;
    logic [STATUS_W-1:0]    hit_status;
    logic [STATUS_W-1:0]    miss_status;

    assign out_free = !r_ovalid || i_m_axis_tready;
    assign hit      = (r_mode == MODE_DUMP) || (r_rd_key == r_key);
    assign at_end   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // Status codes that belong to the running operation.
    always_comb begin
        unique case (r_mode)
            MODE_DEL:  hit_status = ST_REMOVED;
            MODE_FIND: hit_status = ST_FOUND;
            MODE_DUMP: hit_status = ST_LISTED;
            default:   hit_status = ST_ADDED;
        endcase
        miss_status = (r_mode == MODE_DUMP) ? ST_EMPTY : ST_NOT_FOUND;
    end

    // Sequencer: one table entry is judged per cycle unless a hit waits for a busy result
    // register; hits are held back as pending so the final one can carry the last marker.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_w          = r_w;
        n_pend_valid = r_pend_valid;
        n_ovalid     = r_ovalid && !i_m_axis_tready;
        n_ostatus    = r_ostatus;
        n_okey       = r_okey;
        n_oval       = r_oval;
        n_olast      = r_olast;
        mem_we       = 1'b0;
        mem_wa       = r_w[IDX_W-1:0];
        mem_wkey     = r_rd_key;
        mem_wval     = r_rd_val;
        mem_re       = 1'b0;
        mem_ra       = '0;
        load_pend    = 1'b0;
        o_pop        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    o_pop = 1'b1;
                    n_idx = '0;
                    n_w   = '0;
                    if (!i_req.cmd.scan) begin
                        n_state = S_ADD;
                    end else if (r_count != '0) begin
                        mem_re  = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_ADD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b1;
                    if (r_count == CNT_W'(ENTRIES)) begin
                        n_ostatus = ST_FULL;
                        n_okey    = '0;
                        n_oval    = '0;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wa    = r_count[IDX_W-1:0];
                        mem_wkey  = r_key;
                        mem_wval  = r_value;
                        n_count   = r_count + CNT_W'(1);
                        n_ostatus = ST_ADDED;
                        n_okey    = FIELD_W'(r_key);
                        n_oval    = FIELD_W'(r_value);
                    end
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!(hit && r_pend_valid && !out_free)) begin
                    if (hit) begin
                        load_pend    = 1'b1;
                        n_pend_valid = 1'b1;
                        if (r_pend_valid) begin
                            n_ovalid  = 1'b1;
                            n_olast   = 1'b0;
                            n_ostatus = hit_status;
                            n_okey    = FIELD_W'(r_pend_key);
                            n_oval    = FIELD_W'(r_pend_val);
                        end
                    end else if (r_mode == MODE_DEL) begin
                        // Keep the entry, moved down over the removed ones.
                        mem_we = 1'b1;
                        n_w    = r_w + CNT_W'(1);
                    end
                    if (at_end) begin
                        n_state = S_FINISH;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = r_idx + IDX_W'(1);
                        n_idx  = r_idx + IDX_W'(1);
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b1;
                    if (r_pend_valid) begin
                        n_ostatus = hit_status;
                        n_okey    = FIELD_W'(r_pend_key);
                        n_oval    = FIELD_W'(r_pend_val);
                    end else begin
                        n_ostatus = miss_status;
                        n_okey    = '0;
                        n_oval    = '0;
                    end
                    if (r_mode == MODE_DEL) begin
                        n_count = r_w;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_key[mem_wa] <= mem_wkey;
            mem_val[mem_wa] <= mem_wval;
        end
        if (mem_re) begin
            r_rd_key <= mem_key[mem_ra];
            r_rd_val <= mem_val[mem_ra];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_w          <= '0;
            r_pend_valid <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_w          <= n_w;
            r_pend_valid <= n_pend_valid;
            r_ovalid     <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mode  <= i_req.cmd.mode;
            r_key   <= KEY_WIDTH'(i_req.cmd.key);
            r_value <= VALUE_WIDTH'(i_req.cmd.value);
        end
        if (load_pend) begin
            r_pend_key <= r_rd_key;
            r_pend_val <= r_rd_val;
        end
        r_ostatus <= n_ostatus;
        r_okey    <= n_okey;
        r_oval    <= n_oval;
        r_olast   <= n_olast;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_oval, r_okey, r_ostatus};
    assign o_m_axis_tlast  = r_olast;

endmodule

`default_nettype wire

/* hdl/key_value_multimap_table_unit.sv */
// Top level of the key/value multimap table: input queue front end and table back end.
//
// The table keeps up to ENTRIES key/value pairs in insertion order; a key may
// appear more than once. Commands wait in a two-word input queue. Delete, find
// and dump walk the stored entries through the table memory's single read port,
// one entry per cycle unless a result cannot move because the result port is
// stalled. Results leave through one output register; the input queue keeps
// accepting words while a command runs until it is full, and the last result
// of each command is marked with tlast.
`default_nettype none

module key_value_multimap_table_unit
    import kvmt_pkg::*;
#(
    parameter int ENTRIES     = DEF_ENTRIES,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // tdata fields from bit 0 up: mode[1:0], key[33:2], value[65:34], zero pad.
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // tdata fields from bit 0 up: status[2:0], entry_key[34:3], entry_value[66:35], zero pad.
    output logic [M_DATA_W-1:0]      o_m_axis_tdata,
    output logic                     o_m_axis_tlast
);

    t_cmd_req w_req;
    logic     w_pop;

    // Front end with the command queue.
    kvmt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_req           (w_req),
        .i_pop           (w_pop)
    );

    // Back end with the table and the result register.
    kvmt_back #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (w_req),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

/* hdl/kvmt_checker.sv */
// Port-level checks for the key/value multimap table, bound to its top level.
`default_nettype none

module kvmt_checker
    import kvmt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    input  wire logic                o_s_axis_tready,
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic                o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    input  wire logic [M_DATA_W-1:0] o_m_axis_tdata,
    input  wire logic                o_m_axis_tlast
);

    logic [STATUS_W-1:0] w_status;
    logic                w_single;

    assign w_status = o_m_axis_tdata[STATUS_W-1:0];
    assign w_single = (w_status == ST_ADDED) || (w_status == ST_FULL) ||
                      (w_status == ST_NOT_FOUND) || (w_status == ST_EMPTY);

    // A stalled result word holds its valid.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result valid dropped while stalled");

    // A stalled result word holds its payload.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result payload changed while stalled");

    // Added, full, not-found and empty answers stand alone and end their command.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_single |-> o_m_axis_tlast)
        else $error("single-word answer without last marker");

    // Right after reset the queue is open and nothing is offered downstream.
    a_reset_clean: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("block not idle after reset");

endmodule

bind key_value_multimap_table_unit kvmt_checker u_kvmt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking stream testbench for the key/value multimap table unit.
`timescale 1ns / 1ps

module tb_top;
    import kvmt_pkg::*;

    localparam int TABLE_DEPTH = DEF_ENTRIES;
    localparam int MAX_REPORTS = 10;

    // Expected content of one result word.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  key;
        logic [FIELD_W-1:0]  value;
        logic                last;
    } t_table_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Command stream toward the block.
    logic                s_valid = 1'b0;
    logic [S_DATA_W-1:0] s_data = '0;
    logic                s_ready;

    // Result stream from the block.
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [M_DATA_W-1:0] m_data;
    logic                m_last;

    // Shadow copy of the table contents, updated as each command word is accepted.
    logic [FIELD_W-1:0] shadow_keys [TABLE_DEPTH];
    logic [FIELD_W-1:0] shadow_values [TABLE_DEPTH];
    int                 shadow_count = 0;

    t_table_result pending_results [$];
    int            error_count = 0;

    // Idle controls shared by the sender task and the receiver process.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    // Keys reused across commands so that finds and deletes hit stored entries.
    logic [FIELD_W-1:0] key_pool [8];
    int                 pool_size = 4;

    key_value_multimap_table_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // tdata fields from bit 0 up: mode, key, value, zero pad.
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // tdata fields from bit 0 up: status, entry_key, entry_value, zero pad.
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d result words still pending", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Append one expected result word.
    function automatic void queue_result(input logic [STATUS_W-1:0] status,
                                         input logic [FIELD_W-1:0] key,
                                         input logic [FIELD_W-1:0] value);
        t_table_result r;
        r.status = status;
        r.key = key;
        r.value = value;
        r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Work out the result words of one command and apply it to the shadow table.
    function automatic void predict_table_op(input logic [MODE_W-1:0] mode,
                                             input logic [FIELD_W-1:0] key,
                                             input logic [FIELD_W-1:0] value);
        int keep;
        int hits;
        t_table_result tail;
        hits = 0;
        keep = 0;
        case (mode)
            MODE_ADD: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    queue_result(ST_FULL, '0, '0);
                end else begin
                    shadow_keys[shadow_count] = key;
                    shadow_values[shadow_count] = value;
                    shadow_count++;
                    queue_result(ST_ADDED, key, value);
                end
                hits = 1;
            end
            MODE_DEL: begin
                // Matching entries are reported; the rest slide down to close the gaps.
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_keys[i] == key) begin
                        queue_result(ST_REMOVED, shadow_keys[i], shadow_values[i]);
                        hits++;
                    end else begin
                        shadow_keys[keep] = shadow_keys[i];
                        shadow_values[keep] = shadow_values[i];
                        keep++;
                    end
                end
                shadow_count = keep;
                if (hits == 0) queue_result(ST_NOT_FOUND, '0, '0);
            end
            MODE_FIND: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_keys[i] == key) begin
                        queue_result(ST_FOUND, shadow_keys[i], shadow_values[i]);
                        hits++;
                    end
                end
                if (hits == 0) queue_result(ST_NOT_FOUND, '0, '0);
            end
            default: begin
                for (int i = 0; i < shadow_count; i++) begin
                    queue_result(ST_LISTED, shadow_keys[i], shadow_values[i]);
                end
                if (shadow_count == 0) queue_result(ST_EMPTY, '0, '0);
            end
        endcase
        // The final word of every command carries tlast.
        tail = pending_results.pop_back();
        tail.last = 1'b1;
        pending_results.push_back(tail);
    endfunction

    // Offer one command word and wait until it is accepted.
    task automatic send_command(input logic [MODE_W-1:0] mode,
                                input logic [FIELD_W-1:0] key,
                                input logic [FIELD_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data <= {{(S_DATA_W - MODE_W - 2 * FIELD_W){1'b0}}, value, key, mode};
        do @(posedge i_clk); while (!s_ready);
        predict_table_op(mode, key, value);
    endtask

    // Check every accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_table_result got;
        t_table_result want;
        logic          pad_bad;
        if (i_rst_n && m_valid && m_ready) begin
            got.status = m_data[STATUS_W-1:0];
            got.key = m_data[STATUS_W +: FIELD_W];
            got.value = m_data[STATUS_W + FIELD_W +: FIELD_W];
            got.last = m_last;
            pad_bad = (m_data[M_DATA_W-1:STATUS_W + 2 * FIELD_W] != '0);
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("ERROR at %0t: unexpected word status=%0d key=%h value=%h last=%b",
                             $realtime, got.status, got.key, got.value, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.key !== want.key ||
                    got.value !== want.value || got.last !== want.last || pad_bad) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("ERROR at %0t: expected status=%0d key=%h value=%h last=%b",
                                 $realtime, want.status, want.key, want.value, want.last);
                        $display("    got status=%0d key=%h value=%h last=%b pad=%h",
                                 got.status, got.key, got.value, got.last,
                                 m_data[M_DATA_W-1:STATUS_W + 2 * FIELD_W]);
                    end
                end
            end
        end
    end

    // Pick a key, mostly from the shared pool so commands hit stored entries.
    function automatic logic [FIELD_W-1:0] pick_key();
        if ($urandom_range(99) < 75) return key_pool[$urandom_range(pool_size - 1)];
        return $urandom;
    endfunction

    // Refresh the key pool; a small pool gives long runs of duplicates.
    task automatic refill_key_pool();
        pool_size = $urandom_range(8, 2);
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    endtask

    // Empty table, extreme fields, duplicate keys and gap closing on delete.
    task automatic test_basic_ops();
        send_command(MODE_DUMP, 32'h0, 32'h0);
        send_command(MODE_FIND, 32'h0, 32'h0);
        send_command(MODE_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(MODE_ADD, 32'h0, 32'h0);
        send_command(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(MODE_ADD, 32'h0, 32'hA5A5_5A5A);
        send_command(MODE_FIND, 32'h0, 32'hFFFF_FFFF);
        send_command(MODE_DEL, 32'h0, 32'h1234_5678);
        send_command(MODE_DUMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fill the free table slots with one key, overflow it, then find and delete the whole run.
    task automatic test_full_table();
        logic [FIELD_W-1:0] run_key;
        run_key = $urandom;
        while (shadow_count < TABLE_DEPTH) send_command(MODE_ADD, run_key, $urandom);
        send_command(MODE_ADD, $urandom, $urandom);
        send_command(MODE_FIND, run_key, $urandom);
        send_command(MODE_DEL, run_key, $urandom);
    endtask

    // Random command mix under the given sender and receiver idle rates.
    task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
        int pick;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        refill_key_pool();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) send_command(MODE_ADD, pick_key(), $urandom);
            else if (pick < 60) send_command(MODE_DEL, pick_key(), $urandom);
            else if (pick < 85) send_command(MODE_FIND, pick_key(), $urandom);
            else send_command(MODE_DUMP, $urandom, $urandom);
            if ($urandom_range(99) < 3) refill_key_pool();
        end
    endtask

    // Long receiver hold-off while the sender keeps offering; the input must back up.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (shadow_count < TABLE_DEPTH - 2) send_command(MODE_ADD, pick_key(), $urandom);
        // Withdraw the last accepted word before the hold-off starts.
        @(negedge i_clk);
        s_valid <= 1'b0;
        hold_left = 300;
        for (int n = 0; n < 20; n++) begin
            if (n % 3 == 0) send_command(MODE_DUMP, $urandom, $urandom);
            else send_command(MODE_FIND, pick_key(), $urandom);
        end
    endtask

    // Test sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        refill_key_pool();

        test_basic_ops();
        test_full_table();
        test_random_mix(50, 0, 0);
        test_random_mix(50, 56, 0);
        test_random_mix(50, 0, 56);
        test_random_mix(50, 8, 8);
        test_output_backpressure();
        test_random_mix(20, 0, 0);

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
